/* rtl/lrpf_pkg.sv */
// Package: shared constants, types and codes of the linear resampler and PCM formatter.
`timescale 1ns / 1ps
`default_nettype none
package lrpf_pkg;

    localparam int unsigned SOURCE_RATE  = 48000;
    localparam int unsigned MAX_OUT_RATE = 192000;
    localparam int unsigned MAX_FRAMES   = 4;

    localparam int unsigned RATE_W   = 18;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned COUNT_W  = 48;
    localparam int unsigned POS_W    = 64;
    localparam int unsigned QUOT_W   = 17;
    localparam int unsigned DIVD_W   = 34;
    localparam int unsigned PROD_W   = 35;
    localparam int unsigned ACC_W    = 36;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FMT_W    = 2;
    localparam int unsigned NFR_W    = 3;
    localparam int unsigned DCNT_W   = 5;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(SOURCE_RATE);

    // Configuration register indexes
    localparam logic REG_OUTPUT_RATE   = 1'b0;
    localparam logic REG_SAMPLE_FORMAT = 1'b1;

    typedef enum logic [FMT_W-1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2,
        FMT_F32 = 2'd3
    } fmt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

    // Request to and response from the shared divider
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
        logic [RATE_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/linear_resampler_pcm_formatter.sv */
// Top level: sequencer, position tracking, interpolation multiplier and output register.
// Path: a frame on a source sample goes through res_reg to the output register after
// acceptance; an interpolated frame first takes two multiply steps and the shared division.
// Throughput: one sample at a time, ready only while idle; after reset or any write the next
// sample first waits for the step division, and a stalled output holds the sequencer.
// Reset (rst_n, asynchronous, active low): rate 48000, format s16, counters cleared.
`timescale 1ns / 1ps
`default_nettype none
module linear_resampler_pcm_formatter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [17:0] cfg_wdata,
    // Source samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    // Output frames
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [31:0] frame_word, [47:32] frame_sample
    output logic             m_axis_tlast
);

    localparam int unsigned SW = lrpf_pkg::SAMPLE_W;
    localparam int unsigned RW = lrpf_pkg::RATE_W;

    lrpf_pkg::state_t                 state_reg, state_next;
    logic [RW-1:0]                    rate_reg;
    lrpf_pkg::fmt_t                   fmt_reg;
    logic                             stale_reg;
    logic [lrpf_pkg::COUNT_W-1:0]     out_cnt_reg;
    logic [lrpf_pkg::COUNT_W-1:0]     src_cnt_reg;
    logic [lrpf_pkg::POS_W-1:0]       idx_reg;
    logic [RW-1:0]                    rem_reg;
    logic signed [SW-1:0]             prior_reg;
    logic                             prior_valid_reg;
    logic [lrpf_pkg::NFR_W-1:0]       n_reg;
    logic                             pending_reg;
    logic [lrpf_pkg::QUOT_W-1:0]      q0_reg;
    logic [RW-1:0]                    r0_reg;
    logic signed [SW-1:0]             sample_reg;
    logic signed [SW-1:0]             res_reg;
    logic signed [lrpf_pkg::ACC_W-1:0] acc_reg;
    logic                             m_valid_reg;
    logic                             m_last_reg;
    logic [lrpf_pkg::WORD_W-1:0]      m_word_reg;
    logic signed [SW-1:0]             m_sample_reg;

    logic                             rate_ok;
    logic [lrpf_pkg::POS_W-1:0]       pos_begin;
    logic                             rem_nz;
    logic                             stop;
    logic signed [SW-1:0]             older;
    logic signed [SW-1:0]             first;
    logic                             out_free;
    logic signed [SW-1:0]             mul_a;
    logic signed [RW:0]               mul_b;
    logic signed [lrpf_pkg::PROD_W-1:0] prod;
    logic [lrpf_pkg::ACC_W-1:0]       abs_acc;
    logic [lrpf_pkg::DIVD_W-1:0]      mag;
    logic [lrpf_pkg::QUOT_W-1:0]      neg_q;
    logic signed [SW-1:0]             div_res;
    logic [RW:0]                      rem_sum;
    logic                             carry;
    logic                             cnt_wrap;
    logic [lrpf_pkg::POS_W-1:0]       adv_idx;
    logic [RW-1:0]                    adv_rem;
    logic [lrpf_pkg::WORD_W-1:0]      enc_word;

    logic                             accept;
    logic                             push;
    logic                             push_last;
    logic                             take;
    logic                             finish;
    logic signed [SW-1:0]             res_val;
    lrpf_pkg::div_req_t               div_req;
    lrpf_pkg::div_rsp_t               div_rsp;

    // Position tests for the next frame
    assign rate_ok   = (rate_reg != '0) && (rate_reg <= RW'(lrpf_pkg::MAX_OUT_RATE));
    assign pos_begin = {16'b0, src_cnt_reg};
    assign rem_nz    = rem_reg != '0;
    assign stop      = (n_reg == lrpf_pkg::NFR_W'(lrpf_pkg::MAX_FRAMES))
                    || (idx_reg > pos_begin) || (rem_nz && (idx_reg >= pos_begin));
    assign older     = prior_valid_reg ? prior_reg : '0;
    assign first     = (idx_reg == pos_begin) ? sample_reg : older;
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Interpolation multiplier, shared by both weight products
    assign mul_a = (state_reg == lrpf_pkg::ST_MUL_A) ? first : sample_reg;
    assign mul_b = (state_reg == lrpf_pkg::ST_MUL_A) ? $signed({1'b0, rate_reg - rem_reg})
                                                     : $signed({1'b0, rem_reg});
    assign prod  = lrpf_pkg::PROD_W'(mul_a) * lrpf_pkg::PROD_W'(mul_b);

    // Round the magnitude away from zero by half the rate
    assign abs_acc = acc_reg[lrpf_pkg::ACC_W-1] ? lrpf_pkg::ACC_W'(-acc_reg)
                                                : lrpf_pkg::ACC_W'(acc_reg);
    assign mag     = abs_acc[lrpf_pkg::DIVD_W-1:0] + {17'b0, rate_reg[RW-1:1]};

    // Apply the sign and clamp the quotient to int16
    assign neg_q = lrpf_pkg::QUOT_W'(0) - div_rsp.quotient;
    always_comb
    begin
        if (acc_reg[lrpf_pkg::ACC_W-1])
        begin
            div_res = (div_rsp.quotient > lrpf_pkg::QUOT_W'(32768)) ? 16'sh8000
                                                                    : $signed(neg_q[SW-1:0]);
        end
        else
        begin
            div_res = (div_rsp.quotient > lrpf_pkg::QUOT_W'(32767)) ? 16'sh7FFF
                                                  : $signed(div_rsp.quotient[SW-1:0]);
        end
    end

    // Step the source position by SOURCE_RATE / rate
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, r0_reg};
    assign carry    = rem_sum >= {1'b0, rate_reg};
    assign cnt_wrap = &out_cnt_reg;
    assign adv_idx  = cnt_wrap ? '0 : idx_reg + lrpf_pkg::POS_W'(q0_reg)
                                              + lrpf_pkg::POS_W'(carry);
    assign adv_rem  = cnt_wrap ? '0 : (carry ? RW'(rem_sum - {1'b0, rate_reg})
                                            : rem_sum[RW-1:0]);

    lrpf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lrpf_enc u_enc
    (
        .sample (res_reg),
        .fmt    (fmt_reg),
        .word   (enc_word)
    );

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrpf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control
    always_comb
    begin
        state_next       = state_reg;
        s_axis_tready    = 1'b0;
        accept           = 1'b0;
        push             = 1'b0;
        push_last        = 1'b0;
        take             = 1'b0;
        finish           = 1'b0;
        res_val          = first;
        div_req.start    = 1'b0;
        div_req.dividend = mag;
        div_req.divisor  = rate_reg;
        case (state_reg)
            lrpf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && rate_ok)
                begin
                    accept = 1'b1;
                    if (stale_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = lrpf_pkg::DIVD_W'(lrpf_pkg::SOURCE_RATE);
                        state_next       = lrpf_pkg::ST_RECIP;
                    end
                    else
                    begin
                        state_next = lrpf_pkg::ST_CHECK;
                    end
                end
            end
            lrpf_pkg::ST_RECIP:
            begin
                if (div_rsp.done)
                begin
                    state_next = lrpf_pkg::ST_CHECK;
                end
            end
            lrpf_pkg::ST_CHECK:
            begin
                if (!pending_reg || out_free)
                begin
                    push      = pending_reg;
                    push_last = stop;
                    if (stop)
                    begin
                        finish     = 1'b1;
                        state_next = lrpf_pkg::ST_IDLE;
                    end
                    else if (!rem_nz)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        state_next = lrpf_pkg::ST_MUL_A;
                    end
                end
            end
            lrpf_pkg::ST_MUL_A:
            begin
                state_next = lrpf_pkg::ST_MUL_B;
            end
            lrpf_pkg::ST_MUL_B:
            begin
                state_next = lrpf_pkg::ST_DIV_GO;
            end
            lrpf_pkg::ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = lrpf_pkg::ST_DIV_WAIT;
            end
            lrpf_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    take       = 1'b1;
                    res_val    = div_res;
                    state_next = lrpf_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = lrpf_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg        <= lrpf_pkg::RATE_RESET;
            fmt_reg         <= lrpf_pkg::FMT_S16;
            stale_reg       <= 1'b1;
            out_cnt_reg     <= '0;
            src_cnt_reg     <= '0;
            idx_reg         <= '0;
            rem_reg         <= '0;
            prior_reg       <= '0;
            prior_valid_reg <= 1'b0;
            n_reg           <= '0;
            pending_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == lrpf_pkg::REG_OUTPUT_RATE)
            begin
                rate_reg <= cfg_wdata;
            end
            else
            begin
                fmt_reg <= lrpf_pkg::fmt_t'(cfg_wdata[lrpf_pkg::FMT_W-1:0]);
            end
            stale_reg       <= 1'b1;
            out_cnt_reg     <= '0;
            src_cnt_reg     <= '0;
            idx_reg         <= '0;
            rem_reg         <= '0;
            prior_reg       <= '0;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                n_reg       <= '0;
                pending_reg <= 1'b0;
            end
            if (state_reg == lrpf_pkg::ST_RECIP && div_rsp.done)
            begin
                stale_reg <= 1'b0;
            end
            // Advance the output position on each new frame
            if (take)
            begin
                pending_reg <= 1'b1;
                n_reg       <= n_reg + 1'b1;
                out_cnt_reg <= out_cnt_reg + 1'b1;
                idx_reg     <= adv_idx;
                rem_reg     <= adv_rem;
            end
            else if (push)
            begin
                pending_reg <= 1'b0;
            end
            if (finish)
            begin
                src_cnt_reg     <= src_cnt_reg + 1'b1;
                prior_reg       <= sample_reg;
                prior_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= $signed(s_axis_tdata);
        end
        if (state_reg == lrpf_pkg::ST_RECIP && div_rsp.done)
        begin
            q0_reg <= div_rsp.quotient;
            r0_reg <= div_rsp.remainder;
        end
        if (state_reg == lrpf_pkg::ST_MUL_A)
        begin
            acc_reg <= lrpf_pkg::ACC_W'(prod);
        end
        else if (state_reg == lrpf_pkg::ST_MUL_B)
        begin
            acc_reg <= acc_reg + lrpf_pkg::ACC_W'(prod);
        end
        if (take)
        begin
            res_reg <= res_val;
        end
        if (push)
        begin
            m_word_reg   <= enc_word;
            m_sample_reg <= res_reg;
        end
    end

    // Output register: load a beat, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else if (push)
        begin
            m_valid_reg <= 1'b1;
            m_last_reg  <= push_last;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {m_sample_reg, m_word_reg};

endmodule
`default_nettype wire

/* rtl/lrpf_div.sv */
// Shared restoring divider: one quotient bit per cycle, for a 17-bit quotient.
`timescale 1ns / 1ps
`default_nettype none
module lrpf_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrpf_pkg::div_req_t req,
    output lrpf_pkg::div_rsp_t      rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [lrpf_pkg::DCNT_W-1:0]         cnt_reg;
    logic [lrpf_pkg::RATE_W-1:0]         part_reg;
    logic [lrpf_pkg::QUOT_W-1:0]         low_reg;
    logic [lrpf_pkg::RATE_W-1:0]         dsr_reg;
    logic [lrpf_pkg::RATE_W:0]           trial;
    logic [lrpf_pkg::RATE_W:0]           diff;
    logic                                ge;

    // Shift the next dividend bit in and trial-subtract the divisor
    assign trial = {part_reg, low_reg[lrpf_pkg::QUOT_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == lrpf_pkg::DCNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= lrpf_pkg::DCNT_W'(lrpf_pkg::QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lrpf_pkg::DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            part_reg <= {1'b0, req.dividend[lrpf_pkg::DIVD_W-1:lrpf_pkg::QUOT_W]};
            low_reg  <= req.dividend[lrpf_pkg::QUOT_W-1:0];
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            part_reg <= ge ? diff[lrpf_pkg::RATE_W-1:0] : trial[lrpf_pkg::RATE_W-1:0];
            low_reg  <= {low_reg[lrpf_pkg::QUOT_W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = low_reg;
    assign rsp.remainder = part_reg;

endmodule
`default_nettype wire

/* rtl/lrpf_enc.sv */
// Frame word encoder: s16, s24, s32 and exact float32 of sample/32768.
`timescale 1ns / 1ps
`default_nettype none
module lrpf_enc
(
    input  wire logic signed [lrpf_pkg::SAMPLE_W-1:0] sample,
    input  wire lrpf_pkg::fmt_t                       fmt,
    output logic [lrpf_pkg::WORD_W-1:0]               word
);

    logic [lrpf_pkg::SAMPLE_W-1:0] mag;
    logic [3:0]                    msb;
    logic [lrpf_pkg::WORD_W-1:0]   mant;
    logic [7:0]                    expo;
    logic [lrpf_pkg::WORD_W-1:0]   fword;

    // Find the leading one of the magnitude and normalise
    always_comb
    begin
        mag = sample[lrpf_pkg::SAMPLE_W-1] ? lrpf_pkg::SAMPLE_W'(-sample) : sample;
        msb = '0;
        for (int i = 0; i < lrpf_pkg::SAMPLE_W; i++)
        begin
            if (mag[i])
            begin
                msb = 4'(i);
            end
        end
        mant  = lrpf_pkg::WORD_W'(mag) << (5'd23 - {1'b0, msb});
        expo  = 8'd112 + {4'b0, msb};
        fword = (mag == '0) ? '0 : {sample[lrpf_pkg::SAMPLE_W-1], expo, mant[22:0]};
    end

    // Select the word layout
    always_comb
    begin
        case (fmt)
            lrpf_pkg::FMT_S16: word = {16'b0, sample};
            lrpf_pkg::FMT_S24: word = {8'b0, sample, 8'b0};
            lrpf_pkg::FMT_S32: word = {sample, 16'b0};
            lrpf_pkg::FMT_F32: word = fword;
            default:           word = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/lrpf_chk.sv */
// Port checker for the resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lrpf_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Hold a stalled output beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A non-last beat means the sample's frames are still being produced
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken before the last beat of a sample");

    // No beat can appear in the cycle right after a sample is taken
    a_no_instant_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("output beat appeared too soon after input");

endmodule

bind linear_resampler_pcm_formatter lrpf_chk u_lrpf_chk (.*);
`default_nettype wire

/* tb/linear_resampler_pcm_formatter_tb.sv */
// Self-checking testbench for the linear resampler and PCM formatter top level.
`timescale 1ns / 1ps
module linear_resampler_pcm_formatter_tb;

    localparam int SETTLE_CYCLES = 150;   // longest item with four frames, plus slack
    localparam int QUIET_LIMIT   = 5000;  // cycles without any beat before giving up
    localparam int RANDOM_ITEMS  = 210;

    typedef struct packed {
        logic [31:0]        word;
        logic signed [15:0] sample;
        logic               last;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = lrpf_pkg::REG_OUTPUT_RATE;
    logic [17:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [31:0] frame_word, [47:32] frame_sample
    logic        m_axis_tlast;

    // Resampler state as the block should hold it
    logic [17:0]        cur_rate = 18'(lrpf_pkg::SOURCE_RATE);
    lrpf_pkg::fmt_t     cur_fmt = lrpf_pkg::FMT_S16;
    logic [47:0]        frames_made = '0;
    logic [47:0]        samples_used = '0;
    logic signed [15:0] held_sample = '0;
    logic               held_valid = 1'b0;

    logic [15:0] pending_samples[$];
    frame_t      frames_due[$];
    frame_t      want_frame;

    int src_idle_pct = 35;
    int sink_idle_pct = 35;
    int samples_queued = 0;
    int samples_taken = 0;
    int frames_checked = 0;
    int mismatches = 0;
    int settings_run = 0;
    int quiet_cycles = 0;
    int walk = 0;

    linear_resampler_pcm_formatter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Encode one clamped sample into its output word
    function automatic logic [31:0] encode_word(input logic signed [15:0] v,
                                                input lrpf_pkg::fmt_t fmt);
        logic [31:0] mag;
        logic [31:0] mant;
        int          p;
        case (fmt)
            lrpf_pkg::FMT_S16: return {16'h0000, v};
            lrpf_pkg::FMT_S24: return {8'h00, v, 8'h00};
            lrpf_pkg::FMT_S32: return {v, 16'h0000};
            default:
            begin
                if (v == 0)
                    return 32'h0000_0000;
                mag = (v < 0) ? 32'(-int'(v)) : 32'(int'(v));
                p = 0;
                while (p < 15 && (mag >> (p + 1)) != 0)
                    p++;
                mant = (mag << (23 - p)) & 32'h007F_FFFF;
                return {v < 0, 8'(112 + p), mant[22:0]};
            end
        endcase
    endfunction

    // Advance the resampler by one source sample and queue the frames it yields
    function automatic void resample_step(input logic signed [15:0] s);
        longint unsigned num;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned origin;
        longint signed   rate_s;
        longint signed   older;
        longint signed   first;
        longint signed   w;
        longint signed   q;
        frame_t          batch[lrpf_pkg::MAX_FRAMES];
        int              n;
        rate_s = longint'(cur_rate);
        origin = 64'(samples_used);
        if (cur_rate == 0 || cur_rate > lrpf_pkg::MAX_OUT_RATE)
            return;
        n = 0;
        while (n < lrpf_pkg::MAX_FRAMES)
        begin
            num = 64'(frames_made) * 64'(lrpf_pkg::SOURCE_RATE);
            idx = num / 64'(cur_rate);
            rem = num % 64'(cur_rate);
            if (idx > origin || (rem != 0 && idx + 1 > origin))
                break;
            if (held_valid)
                older = held_sample;
            else
                older = 0;
            if (idx == origin)
                first = s;
            else
                first = older;
            q = first;
            // Interpolate between the two neighbours, round half away from zero
            if (rem != 0)
            begin
                w = first * (rate_s - longint'(rem)) + longint'(s) * longint'(rem);
                if (w >= 0)
                    w = w + rate_s / 2;
                else
                    w = w - rate_s / 2;
                q = w / rate_s;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
            end
            batch[n].sample = q[15:0];
            batch[n].word = encode_word(q[15:0], cur_fmt);
            batch[n].last = 1'b0;
            frames_made = frames_made + 48'd1;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                batch[i].last = 1'b1;
            frames_due.insert(frames_due.size(), batch[i]);
        end
        samples_used = samples_used + 48'd1;
        held_sample = s;
        held_valid = 1'b1;
    endfunction

    // Mix of extremes, full-range noise and a slowly moving waveform
    function automatic logic [15:0] next_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (pick < 45)
            return 16'($urandom);
        walk = walk + int'($urandom_range(4095)) - 2048;
        if (walk > 32767)
            walk = 32767;
        if (walk < -32768)
            walk = -32768;
        return 16'(walk);
    endfunction

    function automatic logic [17:0] pick_rate();
        case ($urandom_range(11))
            0: return 18'd192000;
            1: return 18'd191999;
            2: return 18'd96000;
            3: return 18'd44100;
            4: return 18'd32000;
            5: return 18'd22050;
            6: return 18'd11025;
            7: return 18'd8000;
            8: return 18'd48000;
            9, 10: return 18'($urandom_range(192000, 4000));
            default:
            begin
                if ($urandom_range(1) == 0)
                    return 18'd0;
                return 18'($urandom_range(262143, 192001));
            end
        endcase
    endfunction

    // Drive source beats from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                resample_step(s_axis_tdata);
                samples_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_samples.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check every output beat against the oldest predicted frame
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                frames_checked++;
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected frame, expected none, actual word %h sample %h last %b",
                             $realtime, m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want_frame = frames_due.pop_front();
                    if (m_axis_tdata[31:0] !== want_frame.word)
                    begin
                        $display("%0t: frame_word expected %h actual %h",
                                 $realtime, want_frame.word, m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[47:32] !== want_frame.sample)
                    begin
                        $display("%0t: frame_sample expected %h actual %h",
                                 $realtime, want_frame.sample, m_axis_tdata[47:32]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want_frame.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $realtime, want_frame.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $realtime, QUIET_LIMIT);
                $display("linear_resampler_pcm_formatter regression: fail");
                $finish;
            end
        end
    end

    task automatic offer(input logic [15:0] v);
        pending_samples.insert(pending_samples.size(), v);
        samples_queued++;
    endtask

    // Hold until every queued sample is taken and every frame has come out
    task automatic wait_results_in();
        while (samples_taken != samples_queued || frames_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic drain();
        wait_results_in();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; any write restarts the stream
    task automatic write_reg(input logic index, input logic [17:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == lrpf_pkg::REG_OUTPUT_RATE)
            cur_rate = value;
        else
            cur_fmt = lrpf_pkg::fmt_t'(value[1:0]);
        frames_made = '0;
        samples_used = '0;
        held_sample = '0;
        held_valid = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_setting(input logic [17:0] rate, input lrpf_pkg::fmt_t fmt);
        drain();
        write_reg(lrpf_pkg::REG_OUTPUT_RATE, rate);
        write_reg(lrpf_pkg::REG_SAMPLE_FORMAT, 18'(fmt));
        settings_run++;
    endtask

    initial
    begin
        int random_items;
        int phase_len;
        int phase_no;
        random_items = 0;
        phase_no = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: rate equal to source, plain s16
        offer(16'h0000);
        offer(16'h7FFF);
        offer(16'h8000);
        offer(16'hFFFF);
        offer(16'h0001);
        offer(16'h5555);
        offer(16'hAAAA);
        settings_run++;

        // Top rate: four frames per sample, interpolated between extremes
        change_setting(18'd192000, lrpf_pkg::FMT_S24);
        offer(16'h8000);
        offer(16'h7FFF);
        offer(16'h0000);
        offer(16'h3039);

        change_setting(18'd44100, lrpf_pkg::FMT_S32);
        offer(16'h7FFF);
        offer(16'h8000);
        offer(16'hC000);
        offer(16'h1234);

        change_setting(18'd96000, lrpf_pkg::FMT_F32);
        offer(16'h7FFF);
        offer(16'h8000);
        offer(16'h0001);
        offer(16'hFFFF);
        offer(16'h0000);

        // Lowest rate: only the very first frame appears
        change_setting(18'd1, lrpf_pkg::FMT_F32);
        offer(16'h8000);
        offer(16'h4000);

        // Rates out of range produce nothing
        change_setting(18'd0, lrpf_pkg::FMT_S16);
        offer(16'h1111);
        change_setting(18'h3FFFF, lrpf_pkg::FMT_S24);
        offer(16'h2222);

        // Random phases, each after a new setting: rate and format, or format alone
        while (random_items < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(40, 15);
            if ($urandom_range(3) == 0)
            begin
                drain();
                write_reg(lrpf_pkg::REG_SAMPLE_FORMAT, 18'($urandom_range(3)));
                settings_run++;
            end
            else
            begin
                change_setting(pick_rate(), lrpf_pkg::fmt_t'($urandom_range(3)));
            end
            if (phase_no == 2)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct = 35;
                sink_idle_pct = 35;
            end
            for (int i = 0; i < phase_len; i++)
            begin
                // Pause the source mid-phase until the output side catches up
                if (i == phase_len / 2 && (phase_no == 0 || $urandom_range(3) == 0))
                    wait_results_in();
                offer(next_sample());
            end
            random_items += phase_len;
            phase_no++;
        end

        drain();
        $display("Sent %0d source samples across %0d rate and format settings,", samples_taken,
                 settings_run);
        $display("including out-of-range rates; %0d output frames compared.", frames_checked);
        if (mismatches == 0)
            $display("linear_resampler_pcm_formatter regression: pass");
        else
            $display("linear_resampler_pcm_formatter regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/lrpf_pkg.sv
rtl/lrpf_div.sv
rtl/lrpf_enc.sv
rtl/linear_resampler_pcm_formatter.sv
rtl/lrpf_chk.sv
tb/linear_resampler_pcm_formatter_tb.sv
